FILE: rtl/sscs_pkg.sv
// ----------------------------------------------------------------------------
// sscs_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted color set.
// ----------------------------------------------------------------------------
package sscs_pkg;

   localparam int SLOT_COUNT_DEF = 4;
   localparam int OTHER_FIELDS   = 4;
   localparam int COLOR_W        = 16;
   localparam int REL_W          = 2;
   localparam int COUNT_W        = 3;

   localparam logic [COLOR_W-1:0] EMPTY_MARK = 16'hFFFF;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_CMP = 1'b1;

   localparam logic [REL_W-1:0] REL_NEITHER = 2'd0;
   localparam logic [REL_W-1:0] REL_OURS    = 2'd1;
   localparam logic [REL_W-1:0] REL_THEIRS  = 2'd2;

   typedef struct packed {
      logic ins;        // apply insert to slots
      logic cmp_start;  // latch other set, clear walk
      logic step;       // one merge step
      logic emit_add;   // load result of add
      logic emit_cmp;   // load result of compare
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } status_type;

endpackage

FILE: rtl/small_sorted_color_set.sv
// ----------------------------------------------------------------------------
// small_sorted_color_set
// Sorted set of color codes with insert and subset compare against
// another sorted set.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  action, new_color, other_color_0..3
//   rsp      out  rsp_valid/rsp_stall  was_absent, relation, entry_count,
//                                      set_empty
//
// Add: insert is parallel over all slots; a new add can follow unless the result stalls.
// Compare: the transfer latches the other set, the merge walk steps until either set is
// exhausted, and the result loads once the output is free; the sequencer then returns to idle.
// Reset clears all slots to empty at once; no sweep.
// A stalled result holds off the next request transfer.
// ----------------------------------------------------------------------------
module small_sorted_color_set #(
   parameter int SLOT_COUNT = sscs_pkg::SLOT_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [sscs_pkg::COLOR_W-1:0]   req_new_color,
   input  logic [sscs_pkg::COLOR_W-1:0]   req_other_color_0,
   input  logic [sscs_pkg::COLOR_W-1:0]   req_other_color_1,
   input  logic [sscs_pkg::COLOR_W-1:0]   req_other_color_2,
   input  logic [sscs_pkg::COLOR_W-1:0]   req_other_color_3,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_was_absent,
   output logic [sscs_pkg::REL_W-1:0]     rsp_relation,
   output logic [sscs_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                           rsp_set_empty
);

   sscs_pkg::cmd_type    cmd;
   sscs_pkg::status_type status;

   sscs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   sscs_dpath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .new_color       (req_new_color),
      .other_color_0   (req_other_color_0),
      .other_color_1   (req_other_color_1),
      .other_color_2   (req_other_color_2),
      .other_color_3   (req_other_color_3),
      .rsp_was_absent  (rsp_was_absent),
      .rsp_relation    (rsp_relation),
      .rsp_entry_count (rsp_entry_count),
      .rsp_set_empty   (rsp_set_empty)
   );

   a_add_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == sscs_pkg::ACT_ADD)) |=> rsp_valid)
      else $error("add transfer did not produce a result next cycle");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_set_empty) |-> (rsp_entry_count == '0))
      else $error("empty set with nonzero count");

   a_absent_rel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_absent) |-> (rsp_relation == sscs_pkg::REL_NEITHER))
      else $error("add result carries a relation");

   a_rel_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_relation == sscs_pkg::REL_NEITHER) ||
                     (rsp_relation == sscs_pkg::REL_OURS) ||
                     (rsp_relation == sscs_pkg::REL_THEIRS)))
      else $error("bad relation code");

endmodule

FILE: rtl/sscs_ctrl.sv
// ----------------------------------------------------------------------------
// sscs_ctrl
// Sequencer: accepts items, runs the compare walk, owns result valid.
// ----------------------------------------------------------------------------
module sscs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sscs_pkg::cmd_type    cmd,
   input  sscs_pkg::status_type status
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               if (req_action == sscs_pkg::ACT_ADD) begin
                  cmd.ins      = 1'b1;
                  cmd.emit_add = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  cmd.cmp_start = 1'b1;
                  state_in      = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               if (out_free) begin
                  cmd.emit_cmp = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/sscs_dpath.sv
// ----------------------------------------------------------------------------
// sscs_dpath
// Slot store, sorted insert, merge-walk registers and result registers.
// ----------------------------------------------------------------------------
module sscs_dpath #(
   parameter int SLOT_COUNT = sscs_pkg::SLOT_COUNT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sscs_pkg::cmd_type                    cmd,
   output sscs_pkg::status_type                 status,
   input  logic [sscs_pkg::COLOR_W-1:0]         new_color,
   input  logic [sscs_pkg::COLOR_W-1:0]         other_color_0,
   input  logic [sscs_pkg::COLOR_W-1:0]         other_color_1,
   input  logic [sscs_pkg::COLOR_W-1:0]         other_color_2,
   input  logic [sscs_pkg::COLOR_W-1:0]         other_color_3,
   output logic                                 rsp_was_absent,
   output logic [sscs_pkg::REL_W-1:0]           rsp_relation,
   output logic [sscs_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                 rsp_set_empty
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   typedef logic [sscs_pkg::COLOR_W-1:0] color_type;

   color_type slots_ff [SLOT_COUNT];
   color_type slots_in [SLOT_COUNT];
   color_type other_ff [SLOT_COUNT];
   color_type other_load [SLOT_COUNT];
   color_type prev_slot [SLOT_COUNT];
   color_type cnt_src [SLOT_COUNT];
   color_type field_arr [sscs_pkg::OTHER_FIELDS];

   logic [SLOT_COUNT-1:0] hit_vec;
   logic                  eq_hit;
   logic [CNT_W-1:0]      cnt_now, tend_now;
   logic [CNT_W+2:0]      cnt_ext;
   logic [CNT_W-1:0]      ours_ff, theirs_ff, oend_ff, tend_ff;
   logic                  we_big_ff, they_big_ff;
   color_type             walk_a, walk_b;
   logic                  fin_ours, fin_theirs;

   logic                               was_absent_ff;
   logic [sscs_pkg::REL_W-1:0]         relation_ff;
   logic [sscs_pkg::COUNT_W-1:0]       entry_count_ff;
   logic                               set_empty_ff;

   assign field_arr[0] = other_color_0;
   assign field_arr[1] = other_color_1;
   assign field_arr[2] = other_color_2;
   assign field_arr[3] = other_color_3;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_other
      if (g < sscs_pkg::OTHER_FIELDS) begin : g_fld
         assign other_load[g] = field_arr[g];
      end else begin : g_pad
         assign other_load[g] = sscs_pkg::EMPTY_MARK;
      end
      if (g == 0) begin : g_first
         assign prev_slot[g] = sscs_pkg::EMPTY_MARK;
      end else begin : g_rest
         assign prev_slot[g] = slots_ff[g-1];
      end
   end

   // sorted insert: first slot >= color takes it unless equal, larger entries move up
   always_comb begin
      logic found;
      logic after;
      found  = 1'b0;
      eq_hit = 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         hit_vec[k] = !found && (slots_ff[k] >= new_color);
         found      = found || (slots_ff[k] >= new_color);
         eq_hit     = eq_hit || (hit_vec[k] && (slots_ff[k] == new_color));
      end
      after = 1'b0;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (!eq_hit && hit_vec[k]) begin
            slots_in[k] = new_color;
         end else if (!eq_hit && after) begin
            slots_in[k] = prev_slot[k];
         end else begin
            slots_in[k] = slots_ff[k];
         end
         after = after || hit_vec[k];
      end
   end

   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         cnt_src[k] = cmd.emit_add ? slots_in[k] : slots_ff[k];
      end
   end

   // first empty slot = occupied count
   always_comb begin
      cnt_now  = CNT_W'(SLOT_COUNT);
      tend_now = CNT_W'(SLOT_COUNT);
      for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
         if (cnt_src[k] == sscs_pkg::EMPTY_MARK) begin
            cnt_now = CNT_W'(k);
         end
         if (other_load[k] == sscs_pkg::EMPTY_MARK) begin
            tend_now = CNT_W'(k);
         end
      end
   end

   assign cnt_ext = {3'b000, cnt_now};

   assign walk_a     = slots_ff[ours_ff[IDX_W-1:0]];
   assign walk_b     = other_ff[theirs_ff[IDX_W-1:0]];
   assign fin_ours   = (ours_ff == oend_ff);
   assign fin_theirs = (theirs_ff == tend_ff);

   assign status.walk_done = fin_ours || fin_theirs;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOT_COUNT; k++) begin
            slots_ff[k] <= sscs_pkg::EMPTY_MARK;
         end
      end else if (cmd.ins) begin
         slots_ff <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_start) begin
         other_ff    <= other_load;
         ours_ff     <= '0;
         theirs_ff   <= '0;
         oend_ff     <= cnt_now;
         tend_ff     <= tend_now;
         we_big_ff   <= 1'b1;
         they_big_ff <= 1'b1;
      end else if (cmd.step) begin
         if (walk_a == walk_b) begin
            ours_ff   <= ours_ff + CNT_W'(1);
            theirs_ff <= theirs_ff + CNT_W'(1);
         end else if (walk_a < walk_b) begin
            ours_ff     <= ours_ff + CNT_W'(1);
            they_big_ff <= 1'b0;
         end else begin
            theirs_ff <= theirs_ff + CNT_W'(1);
            we_big_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_add) begin
         was_absent_ff  <= !eq_hit;
         relation_ff    <= sscs_pkg::REL_NEITHER;
         entry_count_ff <= cnt_ext[2:0];
         set_empty_ff   <= (slots_in[0] == sscs_pkg::EMPTY_MARK);
      end else if (cmd.emit_cmp) begin
         was_absent_ff  <= 1'b0;
         if (they_big_ff && fin_ours) begin
            relation_ff <= sscs_pkg::REL_THEIRS;
         end else if (we_big_ff && fin_theirs) begin
            relation_ff <= sscs_pkg::REL_OURS;
         end else begin
            relation_ff <= sscs_pkg::REL_NEITHER;
         end
         entry_count_ff <= cnt_ext[2:0];
         set_empty_ff   <= (slots_ff[0] == sscs_pkg::EMPTY_MARK);
      end
   end

   assign rsp_was_absent  = was_absent_ff;
   assign rsp_relation    = relation_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_set_empty   = set_empty_ff;

endmodule

FILE: tb/sv/small_sorted_color_set_test.sv
// ----------------------------------------------------------------------------
// small_sorted_color_set_test
// Self-checking bench for the sorted color set. Adds and compares are pushed
// through the request channel under several idle/stall mixes and one long
// response hold-off. A scoreboard keeps its own copy of the slots, predicts
// each response on request transfer and checks responses field by field.
// ----------------------------------------------------------------------------
module small_sorted_color_set_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [sscs_pkg::SLOT_COUNT_DEF-1:0][sscs_pkg::COLOR_W-1:0] color_row_type;

   typedef struct packed {
      logic                         was_absent;
      logic [sscs_pkg::REL_W-1:0]   relation;
      logic [sscs_pkg::COUNT_W-1:0] entry_count;
      logic                         set_empty;
   } color_result_type;

   class color_set_scoreboard;
      color_row_type    slots;
      color_result_type pending_results [$];
      int unsigned      mismatches;

      function new();
         slots      = '1;
         mismatches = 0;
      endfunction

      function int unsigned occupied(color_row_type row);
         int unsigned n;
         n = 0;
         while (n < sscs_pkg::SLOT_COUNT_DEF && row[n] != sscs_pkg::EMPTY_MARK) n++;
         return n;
      endfunction

      function logic place_color(logic [sscs_pkg::COLOR_W-1:0] color);
         int unsigned                  i;
         logic [sscs_pkg::COLOR_W-1:0] moving;
         logic [sscs_pkg::COLOR_W-1:0] carried;
         i      = 0;
         moving = color;
         while (slots[i] < moving) begin
            i++;
            if (i >= sscs_pkg::SLOT_COUNT_DEF) return 1'b1;
         end
         if (slots[i] == moving) return 1'b0;
         while (slots[i] != sscs_pkg::EMPTY_MARK) begin
            carried  = slots[i];
            slots[i] = moving;
            moving   = carried;
            i++;
            if (i >= sscs_pkg::SLOT_COUNT_DEF) return 1'b1;
         end
         slots[i] = moving;
         return 1'b1;
      endfunction

      function logic [sscs_pkg::REL_W-1:0] relate_sets(color_row_type other);
         int unsigned ours;
         int unsigned theirs;
         int unsigned ours_end;
         int unsigned theirs_end;
         logic        ours_covers;
         logic        theirs_covers;
         ours          = 0;
         theirs        = 0;
         ours_end      = occupied(slots);
         theirs_end    = occupied(other);
         ours_covers   = 1'b1;
         theirs_covers = 1'b1;
         while (ours < ours_end && theirs < theirs_end) begin
            if (slots[ours] == other[theirs]) begin
               ours++;
               theirs++;
            end else if (slots[ours] < other[theirs]) begin
               ours++;
               theirs_covers = 1'b0;
            end else begin
               theirs++;
               ours_covers = 1'b0;
            end
         end
         ours_covers   = ours_covers && (theirs == theirs_end);
         theirs_covers = theirs_covers && (ours == ours_end);
         if (theirs_covers) return sscs_pkg::REL_THEIRS;
         if (ours_covers) return sscs_pkg::REL_OURS;
         return sscs_pkg::REL_NEITHER;
      endfunction

      function void note_request(logic act, logic [sscs_pkg::COLOR_W-1:0] color,
                                 color_row_type other);
         color_result_type want;
         want = '0;
         if (act == sscs_pkg::ACT_ADD) want.was_absent = place_color(color);
         else want.relation = relate_sets(other);
         want.entry_count = sscs_pkg::COUNT_W'(occupied(slots));
         want.set_empty   = (slots[0] == sscs_pkg::EMPTY_MARK);
         pending_results.push_back(want);
      endfunction

      function void check_response(color_result_type got);
         color_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: absent=%0d rel=%0d count=%0d empty=%0d",
                        got.was_absent, got.relation, got.entry_count, got.set_empty);
            return;
         end
         want = pending_results.pop_front();
         if (got.was_absent !== want.was_absent || got.relation !== want.relation ||
             got.entry_count !== want.entry_count || got.set_empty !== want.set_empty) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp absent=%0d rel=%0d count=%0d empty=%0d, ",
                         "got absent=%0d rel=%0d count=%0d empty=%0d"},
                        want.was_absent, want.relation, want.entry_count, want.set_empty,
                        got.was_absent, got.relation, got.entry_count, got.set_empty);
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_action;
   logic [sscs_pkg::COLOR_W-1:0] req_new_color;
   logic [sscs_pkg::COLOR_W-1:0] req_other_color_0;
   logic [sscs_pkg::COLOR_W-1:0] req_other_color_1;
   logic [sscs_pkg::COLOR_W-1:0] req_other_color_2;
   logic [sscs_pkg::COLOR_W-1:0] req_other_color_3;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic                         rsp_was_absent;
   logic [sscs_pkg::REL_W-1:0]   rsp_relation;
   logic [sscs_pkg::COUNT_W-1:0] rsp_entry_count;
   logic                         rsp_set_empty;

   color_set_scoreboard sb;
   int unsigned         idle_pct;
   int unsigned         stall_pct;
   int unsigned         random_sent;
   logic                long_hold;

   small_sorted_color_set u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_new_color     (req_new_color),
      .req_other_color_0 (req_other_color_0),
      .req_other_color_1 (req_other_color_1),
      .req_other_color_2 (req_other_color_2),
      .req_other_color_3 (req_other_color_3),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_was_absent    (rsp_was_absent),
      .rsp_relation      (rsp_relation),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_set_empty     (rsp_set_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // transfer monitor: responses checked, requests predicted
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(color_result_type'({rsp_was_absent, rsp_relation,
                                               rsp_entry_count, rsp_set_empty}));
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_action, req_new_color,
                         {req_other_color_3, req_other_color_2,
                          req_other_color_1, req_other_color_0});
   end

   initial begin : rsp_side
      int unsigned held;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (held = 0; held < 300; held++) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic color_row_type color_row(logic [sscs_pkg::COLOR_W-1:0] a,
                                               logic [sscs_pkg::COLOR_W-1:0] b,
                                               logic [sscs_pkg::COLOR_W-1:0] c,
                                               logic [sscs_pkg::COLOR_W-1:0] d);
      color_row_type row;
      row[0] = a;
      row[1] = b;
      row[2] = c;
      row[3] = d;
      return row;
   endfunction

   task automatic send_item(input logic act, input logic [sscs_pkg::COLOR_W-1:0] color,
                            input color_row_type other);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_new_color     <= color;
      req_other_color_0 <= other[0];
      req_other_color_1 <= other[1];
      req_other_color_2 <= other[2];
      req_other_color_3 <= other[3];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic add_color(input logic [sscs_pkg::COLOR_W-1:0] color);
      send_item(sscs_pkg::ACT_ADD, color, {$urandom, $urandom});
   endtask

   task automatic compare_with(input color_row_type other);
      send_item(sscs_pkg::ACT_CMP, sscs_pkg::COLOR_W'($urandom), other);
   endtask

   // colors drift downward in windows of 16 items so new entries keep
   // displacing old ones in the full set
   task automatic send_random_item();
      int            base;
      int unsigned   pick;
      int unsigned   k;
      int unsigned   filled;
      int unsigned   cand;
      color_row_type other;
      base = 64000 - int'(random_sent / 16) * 1310;
      if (base < 0) base = 0;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if ($urandom_range(49) == 0) add_color(sscs_pkg::EMPTY_MARK);
         else if ($urandom_range(9) == 0)
            add_color(sscs_pkg::COLOR_W'($urandom_range(65534, base)));
         else add_color(sscs_pkg::COLOR_W'(base + $urandom_range(5) * 37));
      end else begin
         pick   = $urandom_range(99);
         other  = '1;
         filled = 0;
         if (pick < 75) begin
            for (k = 0; k < 8; k++) begin
               cand = (k < 6) ? base + k * 37 : base + 1310 + (k - 6) * 37;
               if (filled < sscs_pkg::SLOT_COUNT_DEF && $urandom_range(99) < 45) begin
                  other[filled] = sscs_pkg::COLOR_W'(cand);
                  filled++;
               end
            end
         end else if (pick < 85) begin
            other = {$urandom, $urandom};
         end else if (pick < 95) begin
            other = {$urandom, $urandom};
            other[$urandom_range(sscs_pkg::SLOT_COUNT_DEF - 1)] = sscs_pkg::EMPTY_MARK;
         end
         compare_with(other);
      end
      random_sent++;
   endtask

   localparam logic [sscs_pkg::COLOR_W-1:0] C_A   = 16'd65100;
   localparam logic [sscs_pkg::COLOR_W-1:0] C_B   = 16'd65200;
   localparam logic [sscs_pkg::COLOR_W-1:0] C_C   = 16'd65300;
   localparam logic [sscs_pkg::COLOR_W-1:0] C_E   = 16'd65000;
   localparam logic [sscs_pkg::COLOR_W-1:0] C_TOP = 16'd65534;
   localparam logic [sscs_pkg::COLOR_W-1:0] C_MK  = sscs_pkg::EMPTY_MARK;

   int unsigned idle_mix  [4] = '{0, 77, 0, 21};
   int unsigned stall_mix [4] = '{0, 0, 77, 21};

   initial begin : stimulus
      int unsigned phase;
      sb                = new();
      idle_pct          = 0;
      stall_pct         = 0;
      random_sent       = 0;
      long_hold         = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = sscs_pkg::ACT_ADD;
      req_new_color     = '0;
      req_other_color_0 = '0;
      req_other_color_1 = '0;
      req_other_color_2 = '0;
      req_other_color_3 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty set, marker color, duplicates, fill, push-out, above-all,
      // unsorted and early-terminated other sets
      compare_with('1);
      compare_with(color_row(16'd5, C_MK, C_MK, C_MK));
      add_color(C_MK);
      add_color(C_TOP);
      add_color(C_TOP);
      add_color(C_B);
      compare_with(color_row(C_B, C_TOP, C_MK, C_MK));
      compare_with(color_row(C_B, C_MK, C_MK, C_MK));
      compare_with(color_row(16'd0, C_B, C_TOP, C_MK));
      compare_with(color_row(16'd0, 16'd1, 16'd2, 16'd3));
      add_color(C_C);
      add_color(C_A);
      add_color(C_MK);
      add_color(C_E);
      add_color(C_TOP);
      add_color(C_B);
      compare_with(color_row(C_C, C_E, C_B, C_A));
      compare_with(color_row(C_E, C_MK, C_A, C_B));
      compare_with(color_row(C_E, C_A, C_B, C_C));
      compare_with('0);
      compare_with(color_row(C_TOP, C_TOP, C_TOP, C_TOP));

      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_mix[phase];
         stall_pct = stall_mix[phase];
         repeat (190) send_random_item();
         if (phase == 0) begin
            idle_pct  = 0;
            stall_pct = 0;
            long_hold = 1'b1;
            repeat (40) send_random_item();
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4 * sscs_pkg::SLOT_COUNT_DEF + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sscs_pkg.sv
rtl/sscs_ctrl.sv
rtl/sscs_dpath.sv
rtl/small_sorted_color_set.sv
tb/sv/small_sorted_color_set_test.sv
